// ----- hdl/esa_pkg.sv -----
// Package for the expression stack ALU: codes, payload types, defaults.
`default_nettype none
package esa_pkg;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned DefStackDepth = 64;
	localparam int unsigned DefVarCount = 26;

	typedef enum logic [3:0] {
		ACT_PUSH = 4'd0, ACT_ADD = 4'd1, ACT_SUB = 4'd2, ACT_NEG = 4'd3,
		ACT_MUL = 4'd4, ACT_DIV = 4'd5, ACT_CMP = 4'd6, ACT_STORE = 4'd7,
		ACT_FETCH = 4'd8, ACT_POP = 4'd9, ACT_CLEAR = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2,
		ST_DIVZERO = 3'd3, ST_BADVAR = 3'd4, ST_BADREL = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REL_EQ = 3'd0, REL_LT = 3'd1, REL_LE = 3'd2,
		REL_NE = 3'd3, REL_GT = 3'd4, REL_GE = 3'd5
	} rel_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_SERIAL, S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0] action;
		logic signed [31:0] operand;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [31:0] popped_value;
		logic condition_true;
		logic [6:0] stack_depth;
	} out_item_t;
endpackage
`default_nettype wire

// ----- hdl/expression_stack_alu.sv -----
// Top level: expression stack, variable file and bit-serial arithmetic unit.
`default_nettype none
// Expression stack ALU. Assert start with an item while busy is low; the item
// is transferred at that edge and busy rises. Exactly one result follows,
// shown for one cycle with done high; the receiver cannot stall it, so sample
// it when done is high. busy stays high through the done cycle, so the next
// transfer can come in the cycle after the result. Stack entries live in a
// memory read one address per cycle; an action that reads the stack passes
// through the read states RD1, RD2 and RD3. Push, clear, unused action codes
// and underflow skip the reads and go from RD1 to EXEC and DONE; add, sub,
// neg, compare, store, fetch, pop and divide by zero read, then go through
// EXEC to DONE; mul and div read, then shift one bit per cycle through a
// 32-step serial loop in SERIAL before DONE. Variables are held in flip-flops
// with valid bits; reset clears only those, so no clearing pass is needed.
module expression_stack_alu #(
	parameter int unsigned STACK_DEPTH = esa_pkg::DefStackDepth,
	parameter int unsigned VARIABLE_COUNT = esa_pkg::DefVarCount
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire esa_pkg::in_item_t  in_item,
	output logic                    busy,
	output logic                    done,
	output esa_pkg::out_item_t      result
);
	import esa_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned VW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

	state_t state_q, state_d;
	logic [3:0] act_q;
	logic [31:0] opnd_q;
	logic [CW-1:0] cnt_q;
	// Operands: b = top, r = second; the third entry sits in rd_q during EXEC
	logic [31:0] b_q, r_q;
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [31:0] vars_q [VARIABLE_COUNT];
	logic [VARIABLE_COUNT-1:0] vvalid_q;
	// Serial unit
	logic [5:0] bit_q;
	logic [31:0] acc_q, sh_q, dv_q;
	logic neg_q;
	out_item_t res_q;
	out_item_t res_d;
	logic done_q;

	logic [31:0] abs_a, abs_b, rem_sh, rem_sub;
	logic need_ser;
	logic [2:0] need;

	always_comb begin
		need = 3'd0;
		case (act_q)
			ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_STORE: need = 3'd2;
			ACT_NEG, ACT_FETCH, ACT_POP: need = 3'd1;
			ACT_CMP: need = 3'd3;
			default: need = 3'd0;
		endcase
	end

	// underflow check done in IDLE->RD path via cnt
	logic underflow;
	assign underflow = ({{(32-CW){1'b0}}, cnt_q} < {29'd0, need});

	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_RD1: rd_addr = AW'(cnt_q - CW'(1));
			S_RD2: rd_addr = AW'(cnt_q - CW'(2));
			default: rd_addr = AW'(cnt_q - CW'(3));
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	assign abs_a = r_q[31] ? 32'd0 - r_q : r_q;
	assign abs_b = b_q[31] ? 32'd0 - b_q : b_q;
	assign rem_sh = {acc_q[30:0], sh_q[31]};
	assign rem_sub = rem_sh - dv_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_RD1;
			S_RD1: state_d = (need == 3'd0 || underflow) ? S_EXEC : S_RD2;
			S_RD2: state_d = S_RD3;
			S_RD3: state_d = S_EXEC;
			S_EXEC: state_d = need_ser ? S_SERIAL : S_DONE;
			S_SERIAL: if (bit_q == 6'd31) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != S_IDLE);
		done = done_q;
		result = res_q;
	end

	logic [VW-1:0] vidx;
	logic vidx_ok, rel_ok, holds;
	logic signed [31:0] sa, sb;
	assign need_ser = !underflow && (act_q == ACT_MUL ||
		(act_q == ACT_DIV && b_q != 32'd0));

	always_comb begin
		vidx = (act_q == ACT_FETCH) ? VW'(b_q) : VW'(r_q);
		vidx_ok = (act_q == ACT_FETCH) ? (b_q < 32'(VARIABLE_COUNT))
			: (r_q < 32'(VARIABLE_COUNT));
		rel_ok = r_q < 32'd6;
		// left operand of compare: third entry, read during RD3
		sa = rd_q;
		sb = b_q;
		case (rel_t'(r_q[2:0]))
			REL_EQ: holds = sa == sb;
			REL_LT: holds = sa < sb;
			REL_LE: holds = sa <= sb;
			REL_NE: holds = sa != sb;
			REL_GT: holds = sa > sb;
			default: holds = sa >= sb;
		endcase
	end

	// Result of the item, captured in EXEC
	always_comb begin
		res_d = '0;
		res_d.status = ST_OK;
		res_d.stack_depth = 7'(cnt_q);
		if (underflow) res_d.status = ST_UNDERFLOW;
		else begin
			case (act_q)
				ACT_PUSH: if (cnt_q < CW'(STACK_DEPTH))
					res_d.stack_depth = 7'(cnt_q + CW'(1));
					else res_d.status = ST_OVERFLOW;
				ACT_ADD, ACT_SUB, ACT_MUL: res_d.stack_depth = 7'(cnt_q - CW'(1));
				ACT_DIV: if (b_q == 32'd0) begin
					res_d.status = ST_DIVZERO;
					res_d.stack_depth = 7'(cnt_q - CW'(2));
				end else res_d.stack_depth = 7'(cnt_q - CW'(1));
				ACT_CMP: if (!rel_ok) res_d.status = ST_BADREL;
					else begin
						res_d.condition_true = holds;
						res_d.stack_depth = 7'(cnt_q - CW'(3));
					end
				ACT_STORE: if (!vidx_ok) res_d.status = ST_BADVAR;
					else res_d.stack_depth = 7'(cnt_q - CW'(2));
				ACT_FETCH: if (!vidx_ok) res_d.status = ST_BADVAR;
				ACT_POP: begin
					res_d.popped_value = b_q;
					res_d.stack_depth = 7'(cnt_q - CW'(1));
				end
				ACT_CLEAR: res_d.stack_depth = '0;
				default: res_d.status = ST_OK;
			endcase
		end
	end

	// Memory write selection (EXEC or end of serial op)
	always_comb begin
		we = 1'b0;
		waddr = AW'(cnt_q);
		wdata = opnd_q;
		if (state_q == S_EXEC && !underflow) begin
			case (act_q)
				ACT_PUSH: begin
					we = cnt_q < CW'(STACK_DEPTH);
				end
				ACT_ADD: begin we = 1'b1; waddr = AW'(cnt_q - CW'(2)); wdata = r_q + b_q; end
				ACT_SUB: begin we = 1'b1; waddr = AW'(cnt_q - CW'(2)); wdata = r_q - b_q; end
				ACT_NEG: begin we = 1'b1; waddr = AW'(cnt_q - CW'(1)); wdata = 32'd0 - b_q; end
				ACT_FETCH: begin
					we = vidx_ok; waddr = AW'(cnt_q - CW'(1));
					wdata = vvalid_q[vidx] ? vars_q[vidx] : 32'd0;
				end
				default: we = 1'b0;
			endcase
		end else if (state_q == S_SERIAL && bit_q == 6'd31) begin
			we = 1'b1;
			waddr = AW'(cnt_q - CW'(2));
			if (act_q == ACT_MUL) wdata = sh_q[31] ? acc_q + dv_q : acc_q;
			else begin
				wdata = (rem_sh >= dv_q) ? {sh_q[30:0], 1'b1} : {sh_q[30:0], 1'b0};
				if (neg_q) wdata = 32'd0 - wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			vvalid_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_EXEC && !need_ser) ||
				(state_q == S_SERIAL && bit_q == 6'd31);
			if (state_q == S_EXEC && !underflow) begin
				case (act_q)
					ACT_PUSH: if (cnt_q < CW'(STACK_DEPTH)) cnt_q <= cnt_q + CW'(1);
					ACT_ADD, ACT_SUB: cnt_q <= cnt_q - CW'(1);
					ACT_DIV: if (b_q == 32'd0) cnt_q <= cnt_q - CW'(2);
					ACT_CMP: if (rel_ok) cnt_q <= cnt_q - CW'(3);
					ACT_STORE: if (vidx_ok) begin
						cnt_q <= cnt_q - CW'(2);
						vvalid_q[vidx] <= 1'b1;
					end
					ACT_POP: cnt_q <= cnt_q - CW'(1);
					ACT_CLEAR: cnt_q <= '0;
					default: cnt_q <= cnt_q;
				endcase
			end
			if (state_q == S_SERIAL && bit_q == 6'd31) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) begin
				act_q <= in_item.action;
				opnd_q <= in_item.operand;
			end
			S_RD2: b_q <= rd_q;
			S_RD3: r_q <= rd_q;
			S_EXEC: begin
				bit_q <= '0;
				res_q <= res_d;
				if (act_q == ACT_MUL) begin
					acc_q <= '0;
					sh_q <= b_q;
					dv_q <= r_q;
				end else begin
					acc_q <= '0;
					sh_q <= abs_a;
					dv_q <= abs_b;
					neg_q <= r_q[31] ^ b_q[31];
				end
			end
			S_SERIAL: begin
				bit_q <= bit_q + 6'd1;
				if (act_q == ACT_MUL) begin
					// MSB-first shift-add, low 32 bits kept
					acc_q <= sh_q[31] ? {acc_q[30:0], 1'b0} + {dv_q[30:0], 1'b0}
						: {acc_q[30:0], 1'b0};
					sh_q <= {sh_q[30:0], 1'b0};
				end else begin
					// restoring divide, one quotient bit per cycle
					acc_q <= (rem_sh >= dv_q) ? rem_sub : rem_sh;
					sh_q <= {sh_q[30:0], (rem_sh >= dv_q)};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && !underflow && act_q == ACT_STORE && vidx_ok)
			vars_q[vidx] <= b_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !$past(done))
		else $error("done held two cycles");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after done");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH)) else $error("stack count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer not taken");
endmodule
`default_nettype wire

// ----- tb/expression_stack_alu_tb.sv -----
// Testbench for the expression stack ALU: directed and random transfers against a predictor.
`default_nettype none
module expression_stack_alu_tb;
	import esa_pkg::*;

	localparam int unsigned DEPTH = DefStackDepth;
	localparam int unsigned NVARS = DefVarCount;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Scoreboard: models the stack and variables, and keeps the results still owed.
	class esa_scoreboard;
		logic [31:0] entries [DEPTH];
		int unsigned count;
		logic [31:0] vars [NVARS];
		out_item_t owed [$];
		int errors;

		function new();
			count = 0;
			errors = 0;
			foreach (vars[i]) vars[i] = '0;
			foreach (entries[i]) entries[i] = '0;
		endfunction

		function bit rel_holds(logic [31:0] rel, logic signed [31:0] x, logic signed [31:0] y);
			case (rel)
				REL_EQ: return x == y;
				REL_LT: return x < y;
				REL_LE: return x <= y;
				REL_NE: return x != y;
				REL_GT: return x > y;
				default: return x >= y;
			endcase
		endfunction

		// Apply one accepted item to the model and queue its result.
		function void note_item(in_item_t it);
			out_item_t r;
			logic signed [31:0] a, b;
			logic [31:0] v;
			r = '0;
			r.status = ST_OK;
			case (it.action)
				ACT_PUSH: begin
					if (count >= DEPTH) r.status = ST_OVERFLOW;
					else begin
						entries[count] = it.operand;
						count++;
					end
				end
				ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
					if (count < 2) r.status = ST_UNDERFLOW;
					else begin
						b = entries[count-1];
						a = entries[count-2];
						if (it.action == ACT_DIV && b == 0) begin
							r.status = ST_DIVZERO;
							count -= 2;
						end else begin
							case (it.action)
								ACT_ADD: v = a + b;
								ACT_SUB: v = a - b;
								ACT_MUL: v = a * b;
								default: v = (a == 32'sh8000_0000 && b == -1) ? a : a / b;
							endcase
							entries[count-2] = v;
							count--;
						end
					end
				end
				ACT_NEG: begin
					if (count < 1) r.status = ST_UNDERFLOW;
					else entries[count-1] = 32'd0 - entries[count-1];
				end
				ACT_CMP: begin
					if (count < 3) r.status = ST_UNDERFLOW;
					else if (entries[count-2] > 5) r.status = ST_BADREL;
					else begin
						r.condition_true = rel_holds(entries[count-2], entries[count-3],
							entries[count-1]);
						count -= 3;
					end
				end
				ACT_STORE: begin
					if (count < 2) r.status = ST_UNDERFLOW;
					else if (entries[count-2] >= NVARS) r.status = ST_BADVAR;
					else begin
						vars[entries[count-2]] = entries[count-1];
						count -= 2;
					end
				end
				ACT_FETCH: begin
					if (count < 1) r.status = ST_UNDERFLOW;
					else if (entries[count-1] >= NVARS) r.status = ST_BADVAR;
					else entries[count-1] = vars[entries[count-1]];
				end
				ACT_POP: begin
					if (count < 1) r.status = ST_UNDERFLOW;
					else begin
						r.popped_value = entries[count-1];
						count--;
					end
				end
				ACT_CLEAR: count = 0;
				default: ;
			endcase
			r.stack_depth = count[6:0];
			owed.push_back(r);
		endfunction

		function void check_result(out_item_t got, time t);
			out_item_t exp;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result %h", t, got);
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", t, exp.status, got.status);
				errors++;
			end
			if (got.popped_value !== exp.popped_value) begin
				$display("%0t: popped exp %h got %h", t, exp.popped_value, got.popped_value);
				errors++;
			end
			if (got.condition_true !== exp.condition_true) begin
				$display("%0t: cond exp %b got %b", t, exp.condition_true, got.condition_true);
				errors++;
			end
			if (got.stack_depth !== exp.stack_depth) begin
				$display("%0t: depth exp %0d got %0d", t, exp.stack_depth, got.stack_depth);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	in_item_t in_item;
	logic busy;
	logic done;
	out_item_t result;

	esa_scoreboard stack_model;
	int unsigned cycles;
	bit no_gaps;

	expression_stack_alu u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sample at the rising edge: transfers in and results out.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (start && !busy) stack_model.note_item(in_item);
			if (done) stack_model.check_result(result, $time);
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout");
				$display("expression_stack_alu_tb NOT OK");
				$finish;
			end
		end
	end

	// Offer one item at the falling edge and hold it until it is transferred;
	// start drops only on idle cycles and in drain.
	task automatic send_item(input logic [3:0] act, input logic [31:0] val);
		if (!no_gaps) begin
			while ($urandom_range(99) < 27) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		in_item <= '{action: act, operand: val};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (stack_model.owed.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(30);
			4: return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [3:0] act;
		stack_model = new();
		cycles = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: underflows on empty stack, arithmetic edges, relations, variables.
		send_item(ACT_POP, 0);
		send_item(ACT_ADD, 0);
		send_item(ACT_CMP, 0);
		send_item(ACT_FETCH, 0);
		send_item(ACT_PUSH, 32'h8000_0000);
		send_item(ACT_PUSH, 32'hffff_ffff);
		send_item(ACT_DIV, 0);            // most negative over -1 wraps
		send_item(ACT_PUSH, 32'h7fff_ffff);
		send_item(ACT_PUSH, 0);
		send_item(ACT_DIV, 0);            // divide by zero eats both
		send_item(ACT_PUSH, 32'd7);
		send_item(ACT_PUSH, 32'd9);       // bad relation code
		send_item(ACT_PUSH, 32'd3);
		send_item(ACT_CMP, 0);
		send_item(ACT_POP, 0);
		send_item(ACT_PUSH, 32'd5);       // greater-or-equal
		send_item(ACT_PUSH, 32'hffff_fff9);
		send_item(ACT_CMP, 0);
		send_item(ACT_PUSH, 32'd26);      // bad variable
		send_item(ACT_FETCH, 0);
		send_item(ACT_NEG, 0);
		send_item(ACT_PUSH, 32'd25);
		send_item(ACT_STORE, 0);
		send_item(4'd15, 32'hffff_ffff);  // undefined action is ignored
		send_item(ACT_CLEAR, 0);
		// Fill past the top for overflow
		repeat (DEPTH + 1) send_item(ACT_PUSH, $urandom);
		send_item(ACT_CLEAR, 0);
		drain();                          // sender waits for all owed results

		// Random: mostly well-formed sequences, some noise.
		for (int n = 0; n < 200; n++) begin
			no_gaps = (n >= 80 && n < 120);
			case ($urandom_range(9))
				0, 1: begin // binary op
					send_item(ACT_PUSH, rand_value());
					send_item(ACT_PUSH, rand_value());
					act = 4'($urandom_range(3));
					send_item(act == 0 ? ACT_ADD : act == 1 ? ACT_SUB :
						act == 2 ? ACT_MUL : ACT_DIV, $urandom);
				end
				2: begin // compare
					send_item(ACT_PUSH, rand_value());
					send_item(ACT_PUSH, $urandom_range(7));
					send_item(ACT_PUSH, rand_value());
					send_item(ACT_CMP, $urandom);
				end
				3: begin // store then fetch
					send_item(ACT_PUSH, $urandom_range(27));
					send_item(ACT_PUSH, rand_value());
					send_item(ACT_STORE, $urandom);
					send_item(ACT_PUSH, $urandom_range(27));
					send_item(ACT_FETCH, $urandom);
				end
				4: send_item(ACT_PUSH, rand_value());
				5: send_item(ACT_POP, $urandom);
				6: send_item(ACT_NEG, $urandom);
				7: send_item(4'($urandom_range(15)), rand_value());
				8: if (stack_model.count > 40) send_item(ACT_CLEAR, $urandom);
				   else send_item(ACT_PUSH, $urandom);
				default: send_item(4'($urandom_range(10)), $urandom);
			endcase
		end

		drain();
		if (stack_model.errors == 0)
			$display("expression_stack_alu_tb OK");
		else
			$display("expression_stack_alu_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/esa_pkg.sv
hdl/expression_stack_alu.sv
tb/expression_stack_alu_tb.sv
